@@ rtl/core/apcp_pkg.sv @@
// ----------------------------------------------------------------------------
// apcp_pkg
// Shared types and constants of the audio page cache prefetch policy core.
// ----------------------------------------------------------------------------
package apcp_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int PROT_MAX   = 5;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 40;
    localparam int PF_W       = 20;
    localparam int CUE_W      = 41;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 41;
    localparam int DIV_STEPS  = POS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_END       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUE_LOOP_EN   = 3'd4;

    // result actions
    localparam logic [1:0] ACT_RESIDENT = 2'd0;
    localparam logic [1:0] ACT_LOAD     = 2'd1;
    localparam logic [1:0] ACT_UNPLACED = 2'd2;

    // input commands
    localparam logic CMD_SERVICE    = 1'b0;
    localparam logic CMD_INVALIDATE = 1'b1;

    // divider operand
    typedef enum logic [1:0] {
        OP_POS      = 2'd0,
        OP_CUE_FIRST = 2'd1,
        OP_CUE_LAST  = 2'd2
    } t_op;

    // candidate selection relative to the aligned value
    typedef enum logic [1:0] {
        SEL_THIS = 2'd0,
        SEL_NEXT = 2'd1,
        SEL_PREV = 2'd2
    } t_sel;

    typedef struct packed {
        logic              inval;
        logic              capture;
        logic              div_load;
        t_op               op;
        logic              div_step;
        logic              align;
        logic              add;
        t_sel              sel;
        logic              scan_rd;
        logic              scan_clr;
        logic [SLOT_W-1:0] scan_addr;
        logic              resolve;
        logic [CNT_W-1:0]  pg;
    } t_cmd;

    typedef struct packed {
        logic             pf_zero;
        logic             cue_act;
        logic [CNT_W-1:0] cnt;
    } t_sts;

endpackage

@@ rtl/core/apcp_ram.sv @@
// ----------------------------------------------------------------------------
// apcp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module apcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/apcp_dp.sv @@
// ----------------------------------------------------------------------------
// apcp_dp
// Datapath: configuration, remainder divider, protected list, slot scan.
// ----------------------------------------------------------------------------
module apcp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [apcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [apcp_pkg::POS_W-1:0]          i_position,
    input  apcp_pkg::t_cmd                      i_cmd,
    output apcp_pkg::t_sts                      o_sts,
    output logic [apcp_pkg::POS_W-1:0]          o_page_start,
    output logic [2:0]                          o_slot,
    output logic [1:0]                          o_action,
    output logic                                o_last
);

    localparam int PW = apcp_pkg::POS_W;
    localparam int FW = apcp_pkg::PF_W;
    localparam int SW = apcp_pkg::SLOT_W;
    localparam int CW = apcp_pkg::CNT_W;

    logic [FW-1:0]                r_pf;
    logic [PW-1:0]                r_srclen;
    logic [apcp_pkg::CUE_W-1:0]   r_cue_start;
    logic [apcp_pkg::CUE_W-1:0]   r_cue_end;
    logic                         r_cue_en;

    logic [apcp_pkg::SLOT_COUNT-1:0] r_valid;

    logic [PW-1:0] r_div_q;
    logic [PW-1:0] r_div_src;
    logic [FW-1:0] r_rem;
    logic [PW-1:0] r_aligned;

    logic [PW-1:0] r_list [apcp_pkg::PROT_MAX];
    logic [CW-1:0] r_cnt;

    logic          r_rd_pend;
    logic [SW-1:0] r_rd_slot;
    logic          r_hit;
    logic [SW-1:0] r_hit_slot;
    logic          r_free;
    logic [SW-1:0] r_free_slot;

    logic [PW-1:0] r_out_page;
    logic [2:0]    r_out_slot;
    logic [1:0]    r_out_action;
    logic          r_out_last;

    logic [PW-1:0]   w_rdata;
    logic [FW:0]     w_trial;
    logic            w_ge;
    logic [apcp_pkg::CUE_W-1:0] w_ce;
    logic [PW-1:0]   w_src;
    logic [PW:0]     w_cand;
    logic            w_drop;
    logic            w_dup;
    logic            w_keep;
    logic [PW-1:0]   w_page;
    logic            w_inlist;
    logic            w_empty;
    logic [SW-1:0]   w_empty_slot;
    logic            w_load;
    logic [SW-1:0]   w_slot;

    // divider step: shift one dividend bit into the remainder
    assign w_trial = {r_rem, r_div_q[PW-1]};
    assign w_ge    = w_trial >= {1'b0, r_pf};
    assign w_ce    = r_cue_end - apcp_pkg::CUE_W'(1);

    always_comb begin
        unique case (i_cmd.op)
            apcp_pkg::OP_POS:       w_src = i_position;
            apcp_pkg::OP_CUE_FIRST: w_src = r_cue_start[PW-1:0];
            apcp_pkg::OP_CUE_LAST:  w_src = w_ce[PW-1:0];
            default:                w_src = i_position;
        endcase
    end

    // candidate page and its filter
    always_comb begin
        w_drop = 1'b0;
        unique case (i_cmd.sel)
            apcp_pkg::SEL_THIS: w_cand = {1'b0, r_aligned};
            apcp_pkg::SEL_NEXT: w_cand = {1'b0, r_aligned} + (PW+1)'(r_pf);
            apcp_pkg::SEL_PREV: begin
                w_cand = {1'b0, r_aligned} - (PW+1)'(r_pf);
                w_drop = r_aligned < PW'(r_pf);
            end
            default:            w_cand = {1'b0, r_aligned};
        endcase
    end

    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < apcp_pkg::PROT_MAX; j++) begin
            if ((CW'(j) < r_cnt) && (r_list[j] == w_cand[PW-1:0])) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_keep = !w_drop && (w_cand < {1'b0, r_srclen}) && !w_dup &&
                    (r_cnt < CW'(apcp_pkg::PROT_MAX));

    // scan helpers
    assign w_page = r_list[i_cmd.pg];

    always_comb begin
        w_inlist = 1'b0;
        for (int j = 0; j < apcp_pkg::PROT_MAX; j++) begin
            if ((CW'(j) < r_cnt) && (r_list[j] == w_rdata)) begin
                w_inlist = 1'b1;
            end
        end
    end

    always_comb begin
        w_empty      = 1'b0;
        w_empty_slot = '0;
        for (int s = apcp_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                w_empty      = 1'b1;
                w_empty_slot = SW'(s);
            end
        end
    end

    always_comb begin
        w_load = 1'b0;
        w_slot = '0;
        if (!r_hit) begin
            if (w_empty) begin
                w_load = 1'b1;
                w_slot = w_empty_slot;
            end else if (r_free) begin
                w_load = 1'b1;
                w_slot = r_free_slot;
            end
        end else begin
            w_slot = r_hit_slot;
        end
    end

    apcp_ram #(
        .WIDTH (PW),
        .DEPTH (apcp_pkg::SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.resolve && w_load),
        .i_waddr (w_slot),
        .i_wdata (w_page),
        .i_raddr (i_cmd.scan_addr),
        .o_rdata (w_rdata)
    );

    // configuration and slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf        <= FW'(8192);
            r_srclen    <= '0;
            r_cue_start <= '0;
            r_cue_end   <= '0;
            r_cue_en    <= 1'b0;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    apcp_pkg::CFG_PAGE_FRAMES:   r_pf        <= i_cfg_data[FW-1:0];
                    apcp_pkg::CFG_SOURCE_LENGTH: r_srclen    <= i_cfg_data[PW-1:0];
                    apcp_pkg::CFG_CUE_START:     r_cue_start <= i_cfg_data;
                    apcp_pkg::CFG_CUE_END:       r_cue_end   <= i_cfg_data;
                    apcp_pkg::CFG_CUE_LOOP_EN:   r_cue_en    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.inval) begin
                r_valid <= '0;
            end else if (i_cmd.resolve && w_load) begin
                r_valid[w_slot] <= 1'b1;
            end
            r_rd_pend <= i_cmd.scan_rd;
        end
    end

    // divider, list and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.add && w_keep) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.scan_clr) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_rd_pend) begin
                if (!r_hit && r_valid[r_rd_slot] && (w_rdata == w_page)) begin
                    r_hit <= 1'b1;
                end
                if (!r_free && !w_inlist) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_q   <= w_src;
            r_div_src <= w_src;
            r_rem     <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q <= {r_div_q[PW-2:0], 1'b0};
            r_rem   <= w_ge ? FW'(w_trial - {1'b0, r_pf}) : w_trial[FW-1:0];
        end
        if (i_cmd.align) begin
            r_aligned <= r_div_src - PW'(r_rem);
        end
        if (i_cmd.add && w_keep) begin
            r_list[r_cnt] <= w_cand[PW-1:0];
        end
        if (i_cmd.scan_rd) begin
            r_rd_slot <= i_cmd.scan_addr;
        end
        if (r_rd_pend && !i_cmd.scan_clr) begin
            if (!r_hit && r_valid[r_rd_slot] && (w_rdata == w_page)) begin
                r_hit_slot <= r_rd_slot;
            end
            if (!r_free && !w_inlist) begin
                r_free_slot <= r_rd_slot;
            end
        end
        if (i_cmd.resolve) begin
            r_out_page   <= w_page;
            r_out_slot   <= (r_hit || w_load) ? 3'(w_slot) : 3'd0;
            r_out_action <= r_hit ? apcp_pkg::ACT_RESIDENT :
                            (w_load ? apcp_pkg::ACT_LOAD : apcp_pkg::ACT_UNPLACED);
            r_out_last   <= (i_cmd.pg == (r_cnt - CW'(1)));
        end
    end

    assign o_sts.pf_zero = (r_pf == '0);
    assign o_sts.cue_act = r_cue_en && !r_cue_start[apcp_pkg::CUE_W-1] &&
                           ($signed(r_cue_end) > $signed(r_cue_start));
    assign o_sts.cnt     = r_cnt;

    assign o_page_start = r_out_page;
    assign o_slot       = r_out_slot;
    assign o_action     = r_out_action;
    assign o_last       = r_out_last;

endmodule

@@ rtl/core/apcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// apcp_ctrl
// Controller: sequences division, list build, slot scans and result hand-off.
// ----------------------------------------------------------------------------
module apcp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_cmd_bit,
    input  logic           i_out_ready,
    input  apcp_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output apcp_pkg::t_cmd o_cmd
);

    localparam int SW = apcp_pkg::SLOT_W;
    localparam int CW = apcp_pkg::CNT_W;
    localparam int DW = apcp_pkg::DIV_CNT_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DIV     = 9'b000000010,
        S_ALIGN   = 9'b000000100,
        S_ADD     = 9'b000001000,
        S_NEXT    = 9'b000010000,
        S_SCAN    = 9'b000100000,
        S_DRAIN   = 9'b001000000,
        S_RESOLVE = 9'b010000000,
        S_EMIT    = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [DW-1:0]    r_div_cnt, n_div_cnt;
    apcp_pkg::t_op    r_op, n_op;
    apcp_pkg::t_sel   r_sel, n_sel;
    logic [CW-1:0]    r_pg, n_pg;
    logic [SW-1:0]    r_scan, n_scan;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_op      = r_op;
        n_sel     = r_sel;
        n_pg      = r_pg;
        n_scan    = r_scan;
        o_cmd     = '0;
        o_cmd.op        = r_op;
        o_cmd.sel       = r_sel;
        o_cmd.pg        = r_pg;
        o_cmd.scan_addr = r_scan;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.op   = apcp_pkg::OP_POS;
                if (i_in_valid) begin
                    if (i_cmd_bit == apcp_pkg::CMD_INVALIDATE) begin
                        o_cmd.inval = 1'b1;
                    end else if (!i_sts.pf_zero) begin
                        o_cmd.capture  = 1'b1;
                        o_cmd.div_load = 1'b1;
                        n_op      = apcp_pkg::OP_POS;
                        n_div_cnt = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DW'(apcp_pkg::DIV_STEPS - 1)) begin
                    n_div_cnt = '0;
                    n_state   = S_ALIGN;
                end else begin
                    n_div_cnt = r_div_cnt + DW'(1);
                end
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
                n_sel   = apcp_pkg::SEL_THIS;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                priority if (r_op == apcp_pkg::OP_POS && r_sel == apcp_pkg::SEL_THIS) begin
                    n_sel = apcp_pkg::SEL_NEXT;
                end else if (r_op == apcp_pkg::OP_POS && r_sel == apcp_pkg::SEL_NEXT) begin
                    n_sel = apcp_pkg::SEL_PREV;
                end else if (r_op == apcp_pkg::OP_POS && i_sts.cue_act) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.op       = apcp_pkg::OP_CUE_FIRST;
                    n_op    = apcp_pkg::OP_CUE_FIRST;
                    n_state = S_DIV;
                end else if (r_op == apcp_pkg::OP_CUE_FIRST) begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.op       = apcp_pkg::OP_CUE_LAST;
                    n_op    = apcp_pkg::OP_CUE_LAST;
                    n_state = S_DIV;
                end else begin
                    n_pg    = '0;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_scan = '0;
                if (r_pg == i_sts.cnt) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_clr = (r_scan == '0);
                if (r_scan == SW'(apcp_pkg::SLOT_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_RESOLVE;
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_pg    = r_pg + CW'(1);
                    n_state = S_NEXT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
            r_op      <= apcp_pkg::OP_POS;
            r_sel     <= apcp_pkg::SEL_THIS;
            r_pg      <= '0;
            r_scan    <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
            r_op      <= n_op;
            r_sel     <= n_sel;
            r_pg      <= n_pg;
            r_scan    <= n_scan;
        end
    end

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_div_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_div_cnt == '0))
        else $error("divider count left running");

    a_pg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESOLVE) |-> (r_pg < i_sts.cnt))
        else $error("resolve beyond the protected list");

    a_emit_after_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESOLVE))
        else $error("result shown without a resolve step");

endmodule

@@ rtl/core/audio_page_cache_prefetch_policy_core.sv @@
// ----------------------------------------------------------------------------
// audio_page_cache_prefetch_policy_core
// Prefetch policy for a paged audio cache: protected page set and slot choice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per
//   request: i_cmd selects a service at i_position or an invalidate of all
//   slots. An invalidate completes in the cycle it is taken and gives no
//   results. A service gives up to five results on the output channel
//   (o_out_valid / i_out_ready), one per protected page, with o_last on the
//   final one; with page size zero or an empty protected set it gives none.
//   Each alignment runs a bit-serial remainder divider, then an align step;
//   a service needs one alignment, three with an active cue. Each
//   protected page then takes a scan of the slot RAM at one slot per cycle,
//   a drain step for the registered read, a resolve step and the output
//   step. One transaction is worked at a time and o_in_ready is high only
//   while the block is idle. When the receiver stalls, the result register
//   holds and the block waits. Reset (synchronous, active low) empties every
//   slot and restores the register defaults; no clearing pass is needed.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; an unknown index is dropped.
// ----------------------------------------------------------------------------
module audio_page_cache_prefetch_policy_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [apcp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [apcp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [apcp_pkg::POS_W-1:0]        i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [apcp_pkg::POS_W-1:0]        o_page_start,
    output logic [2:0]                        o_slot,
    output logic [1:0]                        o_action,
    output logic                              o_last
);

    apcp_pkg::t_cmd w_cmd;
    apcp_pkg::t_sts w_sts;

    // sequence the work of one transaction
    apcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd_bit   (i_cmd),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // hold configuration, slot state and the result register
    apcp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_position   (i_position),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_page_start (o_page_start),
        .o_slot       (o_slot),
        .o_action     (o_action),
        .o_last       (o_last)
    );

endmodule

@@ dv/audio_page_cache_prefetch_policy_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_page_cache_prefetch_policy_core_tb
// Self-checking bench: a queue-fed driver sends service and invalidate
// transactions, a shadow of the slot cache predicts every protected-page
// result, and a monitor compares each result transaction field by field.
// ----------------------------------------------------------------------------
module audio_page_cache_prefetch_policy_core_tb;
    import apcp_pkg::*;

    typedef struct {
        logic             cmd;
        logic [POS_W-1:0] position;
    } t_req;

    typedef struct {
        logic [POS_W-1:0] page_start;
        logic [2:0]       slot;
        logic [1:0]       action;
        logic             last;
    } t_page_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd = 1'b0;
    logic [POS_W-1:0]      i_position = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [POS_W-1:0]      o_page_start;
    logic [2:0]            o_slot;
    logic [1:0]            o_action;
    logic                  o_last;

    audio_page_cache_prefetch_policy_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the configuration and of the slot cache
    longint unsigned sh_pf = 8192;
    longint unsigned sh_len = 0;
    longint          sh_cs = 0;
    longint          sh_ce = 0;
    bit              sh_loop = 0;
    bit              sh_valid [SLOT_COUNT];
    longint unsigned sh_page [SLOT_COUNT];

    t_req      pending_reqs[$];
    t_page_res expected_pages[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        fail_count = 0;
    int        req_count = 0;
    int        page_count = 0;

    // Add a page to the protected list unless out of range, already listed or the list is full
    function automatic void protect_page(longint p, ref longint unsigned lst[$]);
        if (p < 0 || longint'(p) >= longint'(sh_len)) return;
        foreach (lst[i]) if (lst[i] == p) return;
        if (lst.size() < PROT_MAX) lst.push_back(p);
    endfunction

    // Work out the results of one transaction and advance the shadow cache
    function automatic void predict_pages(t_req r);
        longint unsigned lst[$];
        longint unsigned cur;
        t_page_res       res;
        int              chosen;
        bit              hit;
        if (r.cmd == CMD_INVALIDATE) begin
            foreach (sh_valid[s]) sh_valid[s] = 0;
            return;
        end
        if (sh_pf == 0) return;
        cur = (r.position / sh_pf) * sh_pf;
        protect_page(cur, lst);
        protect_page(cur + sh_pf, lst);
        protect_page(longint'(cur) - longint'(sh_pf), lst);
        if (sh_loop && sh_cs >= 0 && sh_ce > sh_cs) begin
            protect_page((longint'(sh_cs) / sh_pf) * sh_pf, lst);
            protect_page((longint'(sh_ce - 1) / sh_pf) * sh_pf, lst);
        end
        foreach (lst[k]) begin
            chosen = -1;
            res.action = ACT_UNPLACED;
            for (int s = 0; s < SLOT_COUNT; s++)
                if (chosen < 0 && sh_valid[s] && sh_page[s] == lst[k]) begin
                    chosen = s;
                    res.action = ACT_RESIDENT;
                end
            if (chosen < 0) begin
                for (int s = 0; s < SLOT_COUNT; s++)
                    if (chosen < 0 && !sh_valid[s]) chosen = s;
                if (chosen < 0)
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        hit = 0;
                        foreach (lst[j]) if (lst[j] == sh_page[s]) hit = 1;
                        if (chosen < 0 && !hit) chosen = s;
                    end
                if (chosen >= 0) begin
                    sh_valid[chosen] = 1;
                    sh_page[chosen] = lst[k];
                    res.action = ACT_LOAD;
                end
            end
            res.page_start = POS_W'(lst[k]);
            res.slot = (chosen >= 0) ? chosen[2:0] : 3'd0;
            res.last = (k == lst.size() - 1);
            expected_pages.push_back(res);
        end
    endfunction

    // Driver: present the next queued transaction, hold it until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_pages('{i_cmd, i_position});
                req_count++;
                void'(pending_reqs.pop_front());
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_reqs.size() > (i_in_valid && o_in_ready ? 0 : 0) &&
                        $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_cmd      <= pending_reqs[0].cmd;
                    i_position <= pending_reqs[0].position;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_page_res e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                page_count++;
                if (expected_pages.size() == 0) begin
                    $error("result with no expectation: page_start %0h", o_page_start);
                    fail_count++;
                end else begin
                    e = expected_pages.pop_front();
                    if (o_page_start !== e.page_start) begin
                        $error("page_start expected %0h actual %0h", e.page_start, o_page_start);
                        fail_count++;
                    end
                    if (o_slot !== e.slot) begin
                        $error("slot expected %0d actual %0d", e.slot, o_slot);
                        fail_count++;
                    end
                    if (o_action !== e.action) begin
                        $error("action expected %0d actual %0d", e.action, o_action);
                        fail_count++;
                    end
                    if (o_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, o_last);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold until the block has drained everything queued so far
    task automatic drain_all();
        while (pending_reqs.size() != 0 || i_in_valid || expected_pages.size() != 0)
            @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // Write one register while the block is idle; mirror it in the shadow
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PAGE_FRAMES:   sh_pf = 64'(val[PF_W-1:0]);
            CFG_SOURCE_LENGTH: sh_len = 64'(val[POS_W-1:0]);
            CFG_CUE_START:     sh_cs = longint'($signed(val));
            CFG_CUE_END:       sh_ce = longint'($signed(val));
            CFG_CUE_LOOP_EN:   sh_loop = val[0];
            default: ;
        endcase
    endtask

    task automatic setup(longint unsigned pf, longint unsigned len, longint cs,
                         longint ce, bit lp);
        drain_all();
        write_reg(CFG_PAGE_FRAMES, CFG_DATA_W'(pf));
        write_reg(CFG_SOURCE_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_CUE_START, CFG_DATA_W'(cs));
        write_reg(CFG_CUE_END, CFG_DATA_W'(ce));
        write_reg(CFG_CUE_LOOP_EN, CFG_DATA_W'(lp));
    endtask

    function automatic void push_req(logic c, logic [POS_W-1:0] p);
        pending_reqs.push_back('{c, p});
    endfunction

    // Mostly services near the pages of interest, now and then an invalidate
    task automatic random_burst(int n, longint unsigned span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                push_req(CMD_INVALIDATE, POS_W'({$urandom, $urandom}));
            else if ($urandom_range(9) == 0)
                push_req(CMD_SERVICE, POS_W'({$urandom, $urandom}));
            else
                push_req(CMD_SERVICE, POS_W'({$urandom, $urandom} % span));
        end
    endtask

    initial begin
        foreach (sh_valid[s]) sh_valid[s] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults give an empty list, then extremes and cue
        send_idle_pct = 11; recv_idle_pct = 81;
        push_req(CMD_SERVICE, 40'd100);
        setup(64'd100, 64'd1000, 64'd450, 64'd951, 1'b1);
        push_req(CMD_SERVICE, 40'd0);
        push_req(CMD_SERVICE, 40'd999);
        push_req(CMD_SERVICE, 40'd555);
        push_req(CMD_SERVICE, 40'd250);
        push_req(CMD_SERVICE, 40'd150);
        push_req(CMD_SERVICE, '1);
        push_req(CMD_INVALIDATE, 40'd0);
        push_req(CMD_SERVICE, 40'd300);
        push_req(CMD_INVALIDATE, '1);
        setup(64'd0, 64'd1000, 64'd0, 64'd0, 1'b0);
        push_req(CMD_SERVICE, 40'd5);
        setup(64'hFFFFF, 64'hFF_FFFF_FFFF, -64'sd1099511627776, 64'd1099511627775, 1'b1);
        push_req(CMD_SERVICE, '1);
        push_req(CMD_SERVICE, 40'd0);
        push_req(CMD_SERVICE, 40'h55_5555_5555);
        setup(64'd1, 64'hFF_FFFF_FFFF, 64'd1099511627775, -64'sd1, 1'b1);
        push_req(CMD_SERVICE, 40'hAA_AAAA_AAAA);
        push_req(CMD_SERVICE, '1);
        setup(64'd1, 64'd50, 64'd0, 64'd1099511627775, 1'b1);
        push_req(CMD_SERVICE, 40'd0);
        push_req(CMD_SERVICE, 40'd49);

        // Random phases over several settings
        setup(64'd16, 64'd400, 64'd40, 64'd300, 1'b1);
        random_burst(90, 420);
        setup(64'd1000, 64'd50000, 64'd7000, 64'd9000, 1'b0);
        send_idle_pct = 81; recv_idle_pct = 11;
        random_burst(90, 52000);
        setup(64'($urandom_range(1, 4096)), 64'd20000, 64'($urandom_range(0, 20000)),
              64'($urandom_range(0, 20000)), 1'b1);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_burst(80, 21000);
        drain_all();
        $display("Covered %0d request transactions and %0d page results.",
                 req_count, page_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
